>>> sv/afu_pkg.sv
// Shared types and constants for the activation function unit.
// Holds the function mode codes, the action codes and the default sizes.
// No dependencies.
package afu_pkg;

	// Default word format: signed Q4.12.
	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF = 12;

	// Width of the function mode register.
	localparam int MODE_W = 2;

	// Function mode register codes.
	typedef enum logic [MODE_W-1:0] {
		MODE_SIGMOID = 2'd0,
		MODE_RELU    = 2'd1,
		MODE_TANH    = 2'd2,
		MODE_PASS    = 2'd3
	} mode_t;

	// Action codes carried with each input word.
	localparam logic ACT_FORWARD = 1'b0;
	localparam logic ACT_DERIV   = 1'b1;

endpackage

>>> sv/activation_function_unit.sv
// Activation function unit: sigmoid, clipped leaky ReLU, scaled tanh and pass-through, with derivatives.
// Seven-stage pipeline, one word per cycle; uses afu_pkg for mode and action codes.
//
//   channel   handshake                 payload
//   --------  ------------------------  ------------------------------------
//   input     start / busy              action, operand_value, last_in
//   config    cfg_valid / cfg_ready     cfg_data (function mode)
//   result    result_valid (strobe)     result_value, last_out
//
// A word is taken on every cycle with start high; busy is held low since the
// pipeline never stalls. Each result is on the ports for one cycle; its word passes through
// the seven register stages (input, operand prep, product and PLAN segment, select and
// saturate, reciprocal product, quotient fix, clamp).
// Reset clears the valid bits of every stage and sets the mode to sigmoid.
// The receiver cannot hold results off, so nothing inside ever waits.
module activation_function_unit
	import afu_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         action,
	input  logic signed [DATA_WIDTH-1:0] operand_value,
	input  logic                         last_in,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic        [MODE_W-1:0]     cfg_data,
	output logic                         result_valid,
	output logic signed [DATA_WIDTH-1:0] result_value,
	output logic                         last_out
);

	// Internal widths, all derived from the word format.
	localparam int DW  = DATA_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int VW  = ((DW > F + 1) ? DW : F + 1) + 2;
	localparam int PW  = DW + VW;
	localparam int WV  = (((PW - F) > VW) ? PW - F : VW) + 2;
	localparam int NW  = DW + 6;
	localparam int CW  = (WV > NW) ? WV : NW;
	localparam int PAW = ((DW + 1 > F + 3) ? DW + 1 : F + 3) + 1;
	localparam int SW  = ((NW > F + 1) ? NW : F + 1) + 2;
	localparam int K   = NW;
	localparam int MW  = DW;

	// Reciprocal of 100 scaled by 2^K; the quotient from it is low by at most one.
	localparam logic [63:0]   RECIP64 = (64'd1 << K) / 64'd100;
	localparam logic [MW-1:0] RECIP   = RECIP64[MW-1:0];

	// Magnitude limit ahead of the divider: 100 times the largest output magnitude.
	localparam logic [CW-1:0] SAT_MAG = CW'(100) << (DW - 1);

	// Fixed-point one and the 0.01 constant in the widths where they are used.
	localparam logic signed [VW-1:0] ONE_V = VW'(1) << F;
	localparam logic signed [WV-1:0] ONE_W = WV'(1) << F;
	localparam logic signed [WV-1:0] PCT_W = WV'(((2 ** F) + 50) / 100);
	localparam logic signed [SW-1:0] ONE_S = SW'(1) << F;
	localparam logic signed [SW-1:0] HI_S  = (SW'(1) << (DW - 1)) - SW'(1);
	localparam logic signed [SW-1:0] LO_S  = -(SW'(1) << (DW - 1));

	// PLAN segment bounds and offsets.
	localparam logic [PAW-1:0] P_ONE  = PAW'(1) << F;
	localparam logic [PAW-1:0] P_FIVE = PAW'(5) << F;
	localparam logic [PAW-1:0] P_MID  = PAW'(19) << (F - 3);
	localparam logic [PAW-1:0] P_OFS0 = PAW'(27) << (F - 5);
	localparam logic [PAW-1:0] P_OFS1 = PAW'(5) << (F - 3);
	localparam logic [PAW-1:0] P_OFS2 = PAW'(1) << (F - 1);

	// Configuration register.
	mode_t mode_q;

	// Stage valid bits.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	// Stage payload registers.
	logic                  act_s1, act_s2, act_s3;
	logic                  last_s1, last_s2, last_s3, last_s4, last_s5, last_s6, last_s7;
	mode_t                 mode_s1, mode_s2, mode_s3;
	logic signed [DW-1:0]  x_s1, x_s2, x_s3;
	logic        [DW:0]    pa_s2;
	logic signed [VW-1:0]  mulb_s2;
	logic signed [PW-1:0]  prod_s3;
	logic        [F:0]     plan_s3;
	logic                  neg_s4, neg_s5, neg_s6;
	logic                  div_s4, div_s5;
	logic                  base_s4, base_s5, base_s6;
	logic        [NW-1:0]  n_s4, n_s5;
	logic [NW+MW-1:0]      dprod_s5;
	logic        [NW-1:0]  mag_s6;
	logic signed [DW-1:0]  res_s7;

	// Combinational signals between stages.
	logic        [DW-1:0]  a_c;
	logic        [DW:0]    pa_c;
	logic signed [VW-1:0]  mulb_c;
	logic signed [PW-1:0]  prod_c;
	logic        [F:0]     plan_c;
	logic signed [WV-1:0]  v_c;
	logic                  div_c;
	logic                  base_c;
	logic                  neg_c;
	logic        [NW-1:0]  n_c;
	logic [NW+MW-1:0]      dprod_c;
	logic        [NW-1:0]  mag_c;
	logic signed [DW-1:0]  res_c;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Function mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SIGMOID;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= mode_t'(cfg_data);
		end
	end

	// Valid bits travel down the pipeline one stage per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Stage 2 prep: magnitude, PLAN argument and the second multiplier operand.
	always_comb begin
		logic signed [DW:0] x_ext;
		x_ext = (DW + 1)'(x_s1);
		a_c   = x_s1[DW-1] ? DW'(-x_ext) : DW'(x_ext);
		pa_c  = (mode_s1 == MODE_TANH) ? {a_c, 1'b0} : {1'b0, a_c};
		if (mode_s1 == MODE_SIGMOID) begin
			mulb_c = ONE_V - VW'(x_s1);
		end else begin
			mulb_c = VW'(x_s1);
		end
	end

	// Stage 3 prep: one product and the PLAN piecewise-linear segment.
	always_comb begin
		logic [PAW-1:0] pa_w;
		pa_w   = PAW'(pa_s2);
		prod_c = PW'(x_s2) * PW'(mulb_s2);
		if (pa_w >= P_FIVE) begin
			plan_c = (F + 1)'(P_ONE);
		end else if (pa_w >= P_MID) begin
			plan_c = (F + 1)'((pa_w >> 5) + P_OFS0);
		end else if (pa_w >= P_ONE) begin
			plan_c = (F + 1)'((pa_w >> 3) + P_OFS1);
		end else begin
			plan_c = (F + 1)'((pa_w >> 2) + P_OFS2);
		end
	end

	// Stage 4 prep: select the value per mode, mark division and offset, saturate.
	always_comb begin
		logic signed [WV-1:0] xw;
		logic signed [WV-1:0] pf;
		logic signed [WV-1:0] tw;
		logic signed [WV-1:0] t2;
		logic        [CW-1:0] mag_w;
		xw     = WV'(x_s3);
		pf     = WV'(prod_s3 >>> F);
		tw     = signed'(WV'(plan_s3));
		t2     = (tw <<< 1) - ONE_W;
		v_c    = xw;
		div_c  = 1'b0;
		base_c = 1'b0;
		case (mode_s3)
			MODE_SIGMOID: begin
				if (act_s3 == ACT_DERIV) begin
					v_c = pf;
				end else if (x_s3[DW-1]) begin
					v_c = ONE_W - tw;
				end else begin
					v_c = tw;
				end
			end
			MODE_RELU: begin
				if (act_s3 == ACT_DERIV) begin
					v_c = (x_s3[DW-1] || (xw > ONE_W)) ? PCT_W : ONE_W;
				end else if (x_s3[DW-1]) begin
					div_c = 1'b1;
				end else if (xw > ONE_W) begin
					v_c    = xw - ONE_W;
					div_c  = 1'b1;
					base_c = 1'b1;
				end
			end
			MODE_TANH: begin
				if (act_s3 == ACT_DERIV) begin
					v_c   = ONE_W - pf;
					div_c = x_s3[DW-1];
				end else if (x_s3[DW-1]) begin
					v_c   = -t2;
					div_c = 1'b1;
				end else begin
					v_c = t2;
				end
			end
			default: begin
				if (act_s3 == ACT_DERIV) begin
					v_c = '0;
				end
			end
		endcase
		neg_c = v_c[WV-1];
		mag_w = neg_c ? CW'(-v_c) : CW'(v_c);
		n_c   = (mag_w > SAT_MAG) ? NW'(SAT_MAG) : NW'(mag_w);
	end

	// Stage 5 prep: magnitude times the reciprocal of 100.
	assign dprod_c = (NW + MW)'(n_s4) * (NW + MW)'(RECIP);

	// Stage 6 prep: quotient with a one-step correction, or the magnitude itself.
	always_comb begin
		logic [NW-1:0] q0;
		logic [NW:0]   rem;
		logic [NW-1:0] q;
		q0  = NW'(dprod_s5 >> K);
		rem = (NW + 1)'(n_s5) - ((NW + 1)'(q0) * (NW + 1)'(100));
		q   = (rem >= (NW + 1)'(100)) ? q0 + NW'(1) : q0;
		mag_c = div_s5 ? q : n_s5;
	end

	// Stage 7 prep: restore the sign, add the offset and clamp to the word range.
	always_comb begin
		logic signed [SW-1:0] smag;
		logic signed [SW-1:0] sum;
		smag = signed'(SW'(mag_s6));
		sum  = (neg_s6 ? -smag : smag) + (base_s6 ? ONE_S : SW'(0));
		if (sum > HI_S) begin
			res_c = DW'(HI_S);
		end else if (sum < LO_S) begin
			res_c = DW'(LO_S);
		end else begin
			res_c = DW'(sum);
		end
	end

	// Pipeline payload registers.
	always_ff @(posedge clk) begin
		act_s1  <= action;
		x_s1    <= operand_value;
		last_s1 <= last_in;
		mode_s1 <= mode_q;

		act_s2  <= act_s1;
		x_s2    <= x_s1;
		last_s2 <= last_s1;
		mode_s2 <= mode_s1;
		pa_s2   <= pa_c;
		mulb_s2 <= mulb_c;

		act_s3  <= act_s2;
		x_s3    <= x_s2;
		last_s3 <= last_s2;
		mode_s3 <= mode_s2;
		prod_s3 <= prod_c;
		plan_s3 <= plan_c;

		last_s4 <= last_s3;
		neg_s4  <= neg_c;
		div_s4  <= div_c;
		base_s4 <= base_c;
		n_s4    <= n_c;

		last_s5  <= last_s4;
		neg_s5   <= neg_s4;
		div_s5   <= div_s4;
		base_s5  <= base_s4;
		n_s5     <= n_s4;
		dprod_s5 <= dprod_c;

		last_s6 <= last_s5;
		neg_s6  <= neg_s5;
		base_s6 <= base_s5;
		mag_s6  <= mag_c;

		last_s7 <= last_s6;
		res_s7  <= res_c;
	end

	// Result word straight from the last stage.
	assign result_valid = v_s7;
	assign result_value = res_s7;
	assign last_out     = last_s7;

endmodule
